[rtl/mlr_pkg.sv]
// Shared types, widths, codes and helpers for the midpoint line rasterizer.
package mlr_pkg;

  // Coordinate width of the endpoint and pixel fields
  localparam int COORD_BITS = 10;
  // Walked coordinates in flipped space, signed
  localparam int WALK_W     = COORD_BITS + 2;
  // Midpoint decision variable, signed
  localparam int DEC_W      = COORD_BITS + 3;
  // Absolute deltas, step count and signed flipped origin y
  localparam int DELTA_W    = COORD_BITS + 1;
  // Magnitude of a walked coordinate fed to the stipple divider
  localparam int MAG_W      = COORD_BITS + 1;
  // Divider bit counter
  localparam int DIV_CNT_W  = $clog2(MAG_W);
  // Configuration register widths
  localparam int HEIGHT_W   = COORD_BITS;
  localparam int STIP_W     = 4;
  localparam int CFG_DATA_W = HEIGHT_W;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STIPPLE_LENGTH = 1'b1;

  // Reset values of the configuration registers
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = HEIGHT_W'(600);
  localparam logic [STIP_W-1:0]   STIPPLE_RESET = '0;

  // Input beat modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Dash period residues
  localparam logic [1:0] RES3_ZERO = 2'd0;

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  pixel_on;
    logic                  done_res;
  } out_beat_t;

  // Segment orientation flags
  typedef struct packed {
    logic yneg;
    logic xneg;
    logic steep;
  } line_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Residue mod 3 of (2*r + b), for quotient bits arriving MSB first
  function automatic logic [1:0] mod3_next(input logic [1:0] r, input logic b);
    logic [1:0] res;
    unique case ({r, b})
      3'b000: res = 2'd0;
      3'b001: res = 2'd1;
      3'b010: res = 2'd2;
      3'b011: res = 2'd0;
      3'b100: res = 2'd1;
      3'b101: res = 2'd2;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

[rtl/midpoint_line_rasterizer.sv]
// Midpoint line rasterizer: segment setup, pixel walk and stipple divider.
// A start beat is loaded into the result register and then into the output register; a step
//   beat with stippling on passes first through the restoring divider, one quotient bit per cycle.
// The input stalls until the last beat's pixel is loaded into the output register, so no new
//   beat is taken before that; the stipple divider and a blocked output both hold it off.
// A step beat with no segment in progress is taken and gives no pixel.
// Reset: asynchronous, active low; clears the sequencer, step count and output valid,
//   loads window height 600 and stipple length 0.
module midpoint_line_rasterizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mlr_pkg::in_beat_t                   in_beat_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mlr_pkg::out_beat_t                  out_beat_o,
  input  logic                                cfg_we_i,
  input  logic [mlr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mlr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // Configuration
  logic [mlr_pkg::HEIGHT_W-1:0] height_q;
  logic [mlr_pkg::STIP_W-1:0]   stipple_q;

  // Segment state
  logic signed [mlr_pkg::WALK_W-1:0]  walk_x_q, walk_x_d;
  logic signed [mlr_pkg::WALK_W-1:0]  walk_y_q, walk_y_d;
  logic signed [mlr_pkg::DEC_W-1:0]   dec_q, dec_d;
  logic [mlr_pkg::COORD_BITS-1:0]     origin_x_q;
  logic signed [mlr_pkg::DELTA_W-1:0] origin_y_q, origin_y_d;
  logic [mlr_pkg::DELTA_W-1:0]        dmajor_q, dmajor_d;
  logic [mlr_pkg::DELTA_W-1:0]        dminor_q, dminor_d;
  mlr_pkg::line_class_t               cls_q, cls_d;
  logic [mlr_pkg::DELTA_W-1:0]        steps_left_q, steps_left_d;

  // Sequencer, divider and result holding
  mlr_pkg::state_e                state_q, state_d;
  logic [mlr_pkg::MAG_W-1:0]      div_num_q, div_num_d;
  logic [mlr_pkg::STIP_W-1:0]     div_rem_q, div_rem_d;
  logic [1:0]                     div_q3_q, div_q3_d;
  logic [mlr_pkg::DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;
  mlr_pkg::out_beat_t             res_q, res_d;
  mlr_pkg::out_beat_t             out_beat_q;
  logic                           out_valid_q, out_valid_d;
  logic                           out_load;

  logic in_acc;
  logic is_start;
  logic is_step;
  logic seg_load;
  logic step_load;

  // Setup terms
  logic signed [mlr_pkg::WALK_W-1:0]  h_w;
  logic signed [mlr_pkg::WALK_W-1:0]  xs_w, xe_w, ys_w, ye_w;
  logic signed [mlr_pkg::WALK_W-1:0]  y1_w, y2_w;
  logic signed [mlr_pkg::WALK_W-1:0]  ddx_w, ddy_w;
  logic [mlr_pkg::DELTA_W-1:0]        dx_v, dy_v;
  logic signed [mlr_pkg::WALK_W-1:0]  s_wx, s_wy;
  logic signed [mlr_pkg::DEC_W-1:0]   s_dec;
  logic [mlr_pkg::DELTA_W-1:0]        s_dmaj, s_dmin;
  mlr_pkg::line_class_t               s_cls;

  // Step terms
  logic                               minor_move;
  logic                               axis_walk;
  logic signed [mlr_pkg::WALK_W-1:0]  n_wx, n_wy;
  logic signed [mlr_pkg::DEC_W-1:0]   n_dec;
  logic signed [mlr_pkg::WALK_W-1:0]  ox_w, oy_w;
  logic signed [mlr_pkg::WALK_W-1:0]  px_w, py_w;
  logic signed [mlr_pkg::WALK_W-1:0]  major_w, major_abs;
  logic [mlr_pkg::MAG_W-1:0]          mag_v;

  // Divider step
  logic [mlr_pkg::STIP_W:0]           div_trial;
  logic                               div_ge;
  logic [mlr_pkg::STIP_W:0]           div_diff;
  logic [1:0]                         div_q3_n;

  assign in_stall_o  = (state_q != mlr_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_start    = in_acc && (in_beat_i.mode == mlr_pkg::MODE_START);
  assign is_step     = in_acc && (in_beat_i.mode == mlr_pkg::MODE_STEP);
  assign seg_load    = is_start;
  assign step_load   = is_step && (steps_left_q != '0);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Set up a segment: flip y, take deltas, classify and seed the walk
  always_comb begin
    h_w   = $signed(mlr_pkg::WALK_W'(height_q));
    xs_w  = $signed(mlr_pkg::WALK_W'(in_beat_i.x_start));
    xe_w  = $signed(mlr_pkg::WALK_W'(in_beat_i.x_end));
    ys_w  = $signed(mlr_pkg::WALK_W'(in_beat_i.y_start));
    ye_w  = $signed(mlr_pkg::WALK_W'(in_beat_i.y_end));
    y1_w  = h_w - ys_w;
    y2_w  = h_w - ye_w;
    ddx_w = xe_w - xs_w;
    ddy_w = ys_w - ye_w;
    dx_v  = ddx_w[mlr_pkg::WALK_W-1] ? mlr_pkg::DELTA_W'(-ddx_w) : mlr_pkg::DELTA_W'(ddx_w);
    dy_v  = ddy_w[mlr_pkg::WALK_W-1] ? mlr_pkg::DELTA_W'(-ddy_w) : mlr_pkg::DELTA_W'(ddy_w);
    s_cls.xneg  = (in_beat_i.x_end < in_beat_i.x_start);
    s_cls.yneg  = (in_beat_i.y_start < in_beat_i.y_end);
    s_cls.steep = 1'b0;
    s_wx   = xs_w;
    s_wy   = y1_w;
    s_dec  = '0;
    s_dmin = '0;
    s_dmaj = dx_v;
    priority if (dy_v == '0) begin
      // horizontal or a point: walk from the smaller x
      s_wx = ((xs_w < xe_w) ? xs_w : xe_w) - mlr_pkg::WALK_W'(1);
    end else if (dx_v == '0) begin
      // vertical: walk from the smaller flipped y
      s_cls.steep = 1'b1;
      s_dmaj      = dy_v;
      s_wy        = ((y1_w < y2_w) ? y1_w : y2_w) - mlr_pkg::WALK_W'(1);
    end else if (dy_v < dx_v) begin
      s_dmin = dy_v;
      s_dec  = $signed(mlr_pkg::DEC_W'(dy_v)) - $signed(mlr_pkg::DEC_W'(dx_v >> 1));
    end else begin
      s_cls.steep = 1'b1;
      s_dmaj      = dy_v;
      s_dmin      = dx_v;
      s_dec       = $signed(mlr_pkg::DEC_W'(dx_v)) - $signed(mlr_pkg::DEC_W'(dy_v >> 1));
    end
  end

  // Advance one pixel along the major axis and reflect it back to its quadrant
  always_comb begin
    axis_walk  = (dminor_q == '0);
    minor_move = !dec_q[mlr_pkg::DEC_W-1];
    n_dec      = dec_q;
    n_wx       = walk_x_q;
    n_wy       = walk_y_q;
    if (axis_walk) begin
      if (cls_q.steep) begin
        n_wy = walk_y_q + mlr_pkg::WALK_W'(1);
      end else begin
        n_wx = walk_x_q + mlr_pkg::WALK_W'(1);
      end
    end else begin
      n_dec = dec_q + $signed(mlr_pkg::DEC_W'(dminor_q))
            - (minor_move ? $signed(mlr_pkg::DEC_W'(dmajor_q)) : $signed(mlr_pkg::DEC_W'(0)));
      if (cls_q.steep) begin
        n_wy = walk_y_q + mlr_pkg::WALK_W'(1);
        n_wx = walk_x_q + mlr_pkg::WALK_W'(minor_move);
      end else begin
        n_wx = walk_x_q + mlr_pkg::WALK_W'(1);
        n_wy = walk_y_q + mlr_pkg::WALK_W'(minor_move);
      end
    end
    ox_w = $signed(mlr_pkg::WALK_W'(origin_x_q));
    oy_w = $signed({{(mlr_pkg::WALK_W-mlr_pkg::DELTA_W){origin_y_q[mlr_pkg::DELTA_W-1]}},
                    origin_y_q});
    px_w = (!axis_walk && cls_q.xneg) ? (ox_w <<< 1) - n_wx : n_wx;
    py_w = (!axis_walk && cls_q.yneg) ? h_w + n_wy - (oy_w <<< 1) : h_w - n_wy;
    major_w   = cls_q.steep ? n_wy : n_wx;
    major_abs = major_w[mlr_pkg::WALK_W-1] ? -major_w : major_w;
    mag_v     = major_abs[mlr_pkg::MAG_W-1:0];
  end

  // Restoring divide: one quotient bit per cycle, keep the quotient mod 3
  always_comb begin
    div_trial = {div_rem_q, div_num_q[mlr_pkg::MAG_W-1]};
    div_ge    = (div_trial >= {1'b0, stipple_q});
    div_diff  = div_trial - {1'b0, stipple_q};
    div_q3_n  = mlr_pkg::mod3_next(div_q3_q, div_ge);
  end

  // Sequencer: next state, segment updates, divider and output register load
  always_comb begin
    state_d      = state_q;
    walk_x_d     = walk_x_q;
    walk_y_d     = walk_y_q;
    dec_d        = dec_q;
    origin_y_d   = origin_y_q;
    dmajor_d     = dmajor_q;
    dminor_d     = dminor_q;
    cls_d        = cls_q;
    steps_left_d = steps_left_q;
    div_num_d    = div_num_q;
    div_rem_d    = div_rem_q;
    div_q3_d     = div_q3_q;
    div_cnt_d    = div_cnt_q;
    res_d        = res_q;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      mlr_pkg::ST_IDLE: begin
        if (seg_load) begin
          walk_x_d       = s_wx;
          walk_y_d       = s_wy;
          dec_d          = s_dec;
          origin_y_d     = y1_w[mlr_pkg::DELTA_W-1:0];
          dmajor_d       = s_dmaj;
          dminor_d       = s_dmin;
          cls_d          = s_cls;
          steps_left_d   = s_dmaj;
          res_d.pixel_x  = in_beat_i.x_start;
          res_d.pixel_y  = in_beat_i.y_start;
          res_d.pixel_on = 1'b1;
          res_d.done_res = (s_dmaj == '0);
          state_d        = mlr_pkg::ST_EMIT;
        end else if (step_load) begin
          walk_x_d       = n_wx;
          walk_y_d       = n_wy;
          dec_d          = n_dec;
          steps_left_d   = steps_left_q - mlr_pkg::DELTA_W'(1);
          res_d.pixel_x  = px_w[mlr_pkg::COORD_BITS-1:0];
          res_d.pixel_y  = py_w[mlr_pkg::COORD_BITS-1:0];
          res_d.pixel_on = (stipple_q == '0);
          res_d.done_res = (steps_left_q == mlr_pkg::DELTA_W'(1));
          div_num_d      = mag_v;
          div_rem_d      = '0;
          div_q3_d       = mlr_pkg::RES3_ZERO;
          div_cnt_d      = mlr_pkg::DIV_CNT_W'(mlr_pkg::MAG_W - 1);
          state_d        = (stipple_q == '0) ? mlr_pkg::ST_EMIT : mlr_pkg::ST_DIV;
        end
      end
      mlr_pkg::ST_DIV: begin
        div_num_d = div_num_q << 1;
        div_rem_d = div_ge ? div_diff[mlr_pkg::STIP_W-1:0] : div_trial[mlr_pkg::STIP_W-1:0];
        div_q3_d  = div_q3_n;
        div_cnt_d = div_cnt_q - mlr_pkg::DIV_CNT_W'(1);
        if (div_cnt_q == '0) begin
          res_d.pixel_on = (div_q3_n == mlr_pkg::RES3_ZERO);
          state_d        = mlr_pkg::ST_EMIT;
        end
      end
      mlr_pkg::ST_EMIT: begin
        // hold the pixel until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = mlr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mlr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mlr_pkg::ST_IDLE;
      steps_left_q <= '0;
      out_valid_q  <= 1'b0;
      div_cnt_q    <= '0;
    end else begin
      state_q      <= state_d;
      steps_left_q <= steps_left_d;
      out_valid_q  <= out_valid_d;
      div_cnt_q    <= div_cnt_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q  <= mlr_pkg::HEIGHT_RESET;
      stipple_q <= mlr_pkg::STIPPLE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlr_pkg::REG_WINDOW_HEIGHT:  height_q  <= cfg_data_i;
        mlr_pkg::REG_STIPPLE_LENGTH: stipple_q <= cfg_data_i[mlr_pkg::STIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    walk_x_q   <= walk_x_d;
    walk_y_q   <= walk_y_d;
    dec_q      <= dec_d;
    origin_y_q <= origin_y_d;
    dmajor_q   <= dmajor_d;
    dminor_q   <= dminor_d;
    cls_q      <= cls_d;
    div_num_q  <= div_num_d;
    div_rem_q  <= div_rem_d;
    div_q3_q   <= div_q3_d;
    res_q      <= res_d;
    if (seg_load) begin
      origin_x_q <= in_beat_i.x_start;
    end
    if (out_load) begin
      out_beat_q <= res_q;
    end
  end

`ifndef SYNTHESIS
  // A step with no segment in progress leaves the block idle
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_step && (steps_left_q == '0) |=> state_q == mlr_pkg::ST_IDLE)
    else $error("step without segment did not stay idle");

  // A start loads its first pixel, always on, straight for emission
  a_start_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_start |=> (state_q == mlr_pkg::ST_EMIT) && res_q.pixel_on
                 && (res_q.pixel_x == $past(in_beat_i.x_start)))
    else $error("start pixel not loaded");

  // Divider remainder stays below the stipple length
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mlr_pkg::ST_DIV |-> div_rem_q < stipple_q)
    else $error("divider remainder out of range");

  // Step count only grows on a start
  a_steps_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_start |=> steps_left_q <= $past(steps_left_q))
    else $error("step count grew without a start");

  // A pending pixel waits while the output register is blocked
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlr_pkg::ST_EMIT) && out_valid_o && out_stall_i |=> state_q == mlr_pkg::ST_EMIT)
    else $error("pixel emitted over a blocked output");
`endif

endmodule

[tb/sv/tb_midpoint_line_rasterizer.sv]
// Testbench for the midpoint line rasterizer: random segments, pixel prediction and checking.
module tb_midpoint_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;
  import mlr_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int DASH_PERIOD = 3;
  localparam int DRAIN_WAIT  = 20;
  localparam int N_PHASES    = 8;
  localparam int PHASE_BEATS = 85;
  localparam int LONG_HOLD   = 400;
  localparam int MAX_LOGGED  = 40;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_beat_t              in_beat   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  midpoint_line_rasterizer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Beats waiting to be offered, and pixels the walk is expected to produce
  in_beat_t  pending_beats[$];
  out_beat_t want_pixels[$];

  // Register copy and walk state of the predictor
  logic [HEIGHT_W-1:0]       cur_height = HEIGHT_RESET;
  logic [STIP_W-1:0]         cur_dash   = STIPPLE_RESET;
  logic signed [WALK_W-1:0]  pos_x      = '0;
  logic signed [WALK_W-1:0]  pos_y      = '0;
  logic signed [DEC_W-1:0]   err_term   = '0;
  logic signed [DELTA_W-1:0] org_x      = '0;
  logic signed [DELTA_W-1:0] org_y      = '0;
  logic [DELTA_W-1:0]        d_major    = '0;
  logic [DELTA_W-1:0]        d_minor    = '0;
  line_class_t               cls        = '0;
  logic [DELTA_W-1:0]        left_cnt   = '0;

  // Run bookkeeping
  logic     in_fire     = 1'b0;
  int       err_cnt     = 0;
  int       got_cnt     = 0;
  int       seg_cnt     = 0;
  int       ignored_cnt = 0;
  int       owed_steps  = 0;
  int       gap_left    = 0;
  int       burst_left  = 0;
  int       hold_left   = 0;
  int       holds_done  = 0;
  int       window_left = 0;
  rx_mode_e rx_mode     = RX_OPEN;

  task automatic log_miss(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_LOGGED) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Append a beat to the send queue
  task automatic queue_beat(input in_beat_t b);
    pending_beats = {pending_beats, b};
  endtask

  // Advance the walk model by one accepted beat and queue the pixel it gives
  task automatic predict_pixel(input in_beat_t b);
    int        h, x1, y1, x2, y2, dx, dy, wx, wy, dec, px, py, wmaj, mag;
    logic      minor_move;
    out_beat_t pix;
    h = int'(cur_height);
    if (b.mode == MODE_START) begin
      x1 = int'(b.x_start);
      y1 = h - int'(b.y_start);
      x2 = int'(b.x_end);
      y2 = h - int'(b.y_end);
      dx = (x2 > x1) ? x2 - x1 : x1 - x2;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      org_x = DELTA_W'(x1);
      org_y = DELTA_W'(y1);
      cls = '0;
      cls.xneg = (x2 < x1);
      cls.yneg = (y1 > y2);
      if (dy == 0) begin
        // horizontal or point: walk from the smaller x
        d_major = DELTA_W'(dx);
        d_minor = '0;
        pos_x = WALK_W'(((x1 < x2) ? x1 : x2) - 1);
        pos_y = WALK_W'(y1);
        err_term = '0;
      end else if (dx == 0) begin
        cls.steep = 1'b1;
        d_major = DELTA_W'(dy);
        d_minor = '0;
        pos_x = WALK_W'(x1);
        pos_y = WALK_W'(((y1 < y2) ? y1 : y2) - 1);
        err_term = '0;
      end else if (dy < dx) begin
        d_major = DELTA_W'(dx);
        d_minor = DELTA_W'(dy);
        pos_x = WALK_W'(x1);
        pos_y = WALK_W'(y1);
        err_term = DEC_W'(dy - dx / 2);
      end else begin
        cls.steep = 1'b1;
        d_major = DELTA_W'(dy);
        d_minor = DELTA_W'(dx);
        pos_x = WALK_W'(x1);
        pos_y = WALK_W'(y1);
        err_term = DEC_W'(dx - dy / 2);
      end
      left_cnt = d_major;
      pix.pixel_x  = COORD_BITS'(x1);
      pix.pixel_y  = COORD_BITS'(h - y1);
      pix.pixel_on = 1'b1;
      seg_cnt++;
    end else if (left_cnt != 0) begin
      wx  = int'(pos_x);
      wy  = int'(pos_y);
      dec = int'(err_term);
      if (d_minor == 0) begin
        // axis-aligned: no reflection
        if (cls.steep) wy++;
        else wx++;
        px = wx;
        py = h - wy;
      end else begin
        minor_move = (dec >= 0);
        if (minor_move) dec = dec + int'(d_minor) - int'(d_major);
        else dec = dec + int'(d_minor);
        if (cls.steep) begin
          wy++;
          if (minor_move) wx++;
        end else begin
          wx++;
          if (minor_move) wy++;
        end
        px = cls.xneg ? 2 * int'(org_x) - wx : wx;
        py = cls.yneg ? h + wy - 2 * int'(org_y) : h - wy;
      end
      pos_x    = WALK_W'(wx);
      pos_y    = WALK_W'(wy);
      err_term = DEC_W'(dec);
      left_cnt = left_cnt - 1'b1;
      wmaj = cls.steep ? wy : wx;
      mag  = (wmaj < 0) ? -wmaj : wmaj;
      pix.pixel_x = COORD_BITS'(px);
      pix.pixel_y = COORD_BITS'(py);
      if (cur_dash == '0) pix.pixel_on = 1'b1;
      else pix.pixel_on = ((mag / int'(cur_dash)) % DASH_PERIOD) == 0;
    end else begin
      // step with no segment in progress: nothing comes out
      ignored_cnt++;
      return;
    end
    pix.done_res = (left_cnt == 0);
    want_pixels = {want_pixels, pix};
  endtask

  // Sample both handshakes, track register writes and score every pixel
  always @(posedge clk) begin
    out_beat_t want;
    in_fire <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_WINDOW_HEIGHT:  cur_height = cfg_data[HEIGHT_W-1:0];
          REG_STIPPLE_LENGTH: cur_dash   = cfg_data[STIP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got_cnt++;
        if (want_pixels.size() == 0) begin
          log_miss($sformatf("pixel (%0d,%0d) with none expected",
                             out_beat.pixel_x, out_beat.pixel_y));
        end else begin
          want = want_pixels.pop_front();
          if (out_beat.pixel_x !== want.pixel_x)
            log_miss($sformatf("pixel %0d: x %0d, expected %0d",
                               got_cnt, out_beat.pixel_x, want.pixel_x));
          if (out_beat.pixel_y !== want.pixel_y)
            log_miss($sformatf("pixel %0d: y %0d, expected %0d",
                               got_cnt, out_beat.pixel_y, want.pixel_y));
          if (out_beat.pixel_on !== want.pixel_on)
            log_miss($sformatf("pixel %0d: on %b, expected %b",
                               got_cnt, out_beat.pixel_on, want.pixel_on));
          if (out_beat.done_res !== want.done_res)
            log_miss($sformatf("pixel %0d: done %b, expected %b",
                               got_cnt, out_beat.done_res, want.done_res));
        end
      end
      if (in_valid && !in_stall) predict_pixel(in_beat);
    end
  end

  // Offer pending beats in bursts with random gaps; hold a stalled beat
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_fire) begin
        void'(pending_beats.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (!(in_valid && !in_fire)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          if ($urandom_range(0, 15) == 0) gap_left = 20;
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_valid <= 1'b1;
          in_beat  <= pending_beats[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the output on a pattern that changes at the end of each random window; twice hold off long
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && got_cnt >= 300 + holds_done * 900) begin
      hold_left = LONG_HOLD;
      holds_done++;
      out_stall <= 1'b1;
    end else begin
      if (window_left == 0) begin
        rx_mode     = rx_mode_e'($urandom_range(0, 3));
        window_left = $urandom_range(16, 80);
      end
      window_left--;
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ((window_left & 2) != 0);
      endcase
    end
  end

  function automatic in_beat_t start_beat(input int xs, input int ys, input int xe,
                                          input int ye);
    in_beat_t b;
    b.mode    = MODE_START;
    b.x_start = COORD_BITS'(xs);
    b.y_start = COORD_BITS'(ys);
    b.x_end   = COORD_BITS'(xe);
    b.y_end   = COORD_BITS'(ye);
    return b;
  endfunction

  // Step beats carry random endpoint bits that the block must ignore
  function automatic in_beat_t step_beat();
    in_beat_t b;
    b.mode    = MODE_STEP;
    b.x_start = COORD_BITS'($urandom_range(0, COORD_MAX));
    b.y_start = COORD_BITS'($urandom_range(0, COORD_MAX));
    b.x_end   = COORD_BITS'($urandom_range(0, COORD_MAX));
    b.y_end   = COORD_BITS'($urandom_range(0, COORD_MAX));
    return b;
  endfunction

  // Second endpoint within span of c, kept on screen
  function automatic int pick_end(input int c, input int span);
    int off;
    off = $urandom_range(0, span);
    if ($urandom_range(0, 1) == 1) off = -off;
    if (c + off > COORD_MAX || c + off < 0) off = -off;
    if (c + off > COORD_MAX || c + off < 0) return $urandom_range(0, COORD_MAX);
    return c + off;
  endfunction

  // Queue mostly complete segments, some cut short or overrun, some stray steps
  task automatic queue_phase(input int n_beats);
    int made, kind, span, x1, y1, x2, y2, dx, dy, major;
    made = 0;
    while (made < n_beats) begin
      if (owed_steps != 0) begin
        queue_beat(step_beat());
        owed_steps--;
        made++;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
          repeat ($urandom_range(1, 3)) queue_beat(step_beat());
        end else begin
          span = (kind < 88) ? 12 : ((kind < 97) ? 60 : COORD_MAX);
          x1 = $urandom_range(0, COORD_MAX);
          y1 = $urandom_range(0, COORD_MAX);
          x2 = pick_end(x1, span);
          y2 = pick_end(y1, span);
          case ($urandom_range(0, 9))
            0: y2 = y1;
            1: x2 = x1;
            2: begin
              x2 = x1;
              y2 = y1;
            end
            3: begin
              // diagonal: equal deltas take the steep branch
              dx = (x2 > x1) ? x2 - x1 : x1 - x2;
              if (y1 + dx <= COORD_MAX) y2 = y1 + dx;
              else if (y1 - dx >= 0) y2 = y1 - dx;
            end
            default: ;
          endcase
          dx = (x2 > x1) ? x2 - x1 : x1 - x2;
          dy = (y2 > y1) ? y2 - y1 : y1 - y2;
          major = (dx > dy) ? dx : dy;
          queue_beat(start_beat(x1, y1, x2, y2));
          made++;
          owed_steps = major;
          if (span == COORD_MAX) owed_steps = $urandom_range(0, (major < 40) ? major : 40);
          else if ($urandom_range(0, 9) == 0) owed_steps = $urandom_range(0, major);
          else if ($urandom_range(0, 9) == 0) owed_steps = major + $urandom_range(1, 3);
        end
      end
    end
  endtask

  // Wait until every queued beat is taken and every pixel has come back
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || want_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Stimulus: directed segments at reset settings, then random phases
  initial begin
    int h_set, d_set;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray step, point, horizontal, vertical from below the window, both slopes, overrun
    queue_beat(step_beat());
    queue_beat(start_beat(5, 5, 5, 5));
    queue_beat(step_beat());
    queue_beat(start_beat(10, 100, 13, 100));
    repeat (3) queue_beat(step_beat());
    queue_beat(start_beat(0, 1023, 0, 1020));
    repeat (3) queue_beat(step_beat());
    queue_beat(start_beat(1023, 0, 1019, 2));
    repeat (4) queue_beat(step_beat());
    queue_beat(start_beat(1020, 6, 1023, 0));
    repeat (6) queue_beat(step_beat());
    queue_beat(step_beat());

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: begin
          h_set = COORD_MAX;
          d_set = 15;
        end
        1: begin
          h_set = 0;
          d_set = 1;
        end
        2: begin
          h_set = COORD_MAX;
          d_set = 0;
        end
        3: begin
          h_set = 600;
          d_set = 3;
        end
        default: begin
          h_set = $urandom_range(0, COORD_MAX);
          d_set = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      endcase
      // upper data bits are don't-care for the dash length
      write_reg(REG_WINDOW_HEIGHT, h_set);
      write_reg(REG_STIPPLE_LENGTH, d_set | ($urandom_range(0, 63) << STIP_W));
      @(posedge clk);
      if (p == 2) begin
        // one full walk of the longest diagonal
        queue_beat(start_beat(0, COORD_MAX, COORD_MAX, 0));
        repeat (COORD_MAX) queue_beat(step_beat());
        owed_steps = 0;
      end
      queue_phase(PHASE_BEATS);
    end
    drain();

    if (want_pixels.size() != 0)
      log_miss($sformatf("%0d expected pixels never arrived", want_pixels.size()));
    $display("Walked %0d segments over %0d register settings; %0d pixels checked,",
             seg_cnt, N_PHASES + 1, got_cnt);
    $display("%0d idle steps dropped, %0d long output hold-offs, %0d mismatches.",
             ignored_cnt, holds_done, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2000000;
    $display("TIMEOUT: %0d pixels still expected", want_pixels.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
